[src/wbc_pkg.sv]
`default_nettype none
package wbc_pkg;

  // register index map
  localparam logic [1:0] REG_SPEED_SCALE  = 2'd0;
  localparam logic [1:0] REG_FILTER_ALPHA = 2'd1;
  localparam logic [1:0] REG_LEAN_GAIN    = 2'd2;
  localparam logic [1:0] REG_BALANCE_GAIN = 2'd3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [15:0] SPEED_SCALE_RST  = 16'd4267;
  localparam logic [16:0] FILTER_ALPHA_RST = 17'd6554;
  localparam logic [15:0] LEAN_GAIN_RST    = 16'd51;
  localparam logic [15:0] BALANCE_GAIN_RST = 16'd640;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // in_tuser mode codes
  localparam logic MODE_STEP  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // field widths
  localparam int POS_W   = 32;
  localparam int PITCH_W = 17;
  localparam int GOAL_W  = 16;
  localparam int SPEED_W = 32;
  localparam int CORR_W  = 24;

  localparam int IN_DATA_W  = 104;  // 97 field bits, zero padded to bytes
  localparam int OUT_DATA_W = 120;

  // shared multiplier operands: signed 33 x signed 18
  localparam int OPA_W  = 33;
  localparam int OPB_W  = 18;
  localparam int PROD_W = OPA_W + OPB_W;

  // fixed point shifts
  localparam int SPEED_SHIFT = 9;
  localparam int ALPHA_SHIFT = 16;
  localparam int GAIN_SHIFT  = 8;

endpackage
`default_nettype wire

[src/wheel_balance_controller_unit.sv]
`default_nettype none
// Wheel balance controller: cascaded proportional balance loop, one input
// beat per control tick.
//
// Input channel (in_*): one beat per tick. in_tuser is the mode: 0 runs a
// control step, 1 is a start beat that captures the wheel positions and
// clears the speed filter; a start beat yields no output beat.
// Output channel (out_*): one beat per control step with both wheel position
// commands, the filtered speed and the saturated pitch correction.
// Config port (cfg_*): write-only, one register per cycle. Registers are to be
// written only while idle; the block itself does not enforce this.
// Sequencing: one shared 33x18 signed multiplier does four products per step
// (speed scale, filter weight, lean gain, balance gain), each passing through
// a multiply state and a post-processing state. in_tready rises together with
// out_tvalid at the end of a control step; a start beat leaves the sequencer
// idle, so it is ready for the next beat at once.
// The result sits in an output register, so a new beat is taken while it
// waits; a stalled receiver only holds the sequencer when a second result is
// ready and the register is still full.
// Reset (rst_n low, synchronous) restores the default gains, zeroes the
// stored positions and the filter, and empties the output register.
module wheel_balance_controller_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  // [31:0] left_position, [63:32] right_position, [80:64] body_pitch,
  // [96:81] goal_speed, [103:97] zero
  input  wire logic [wbc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] mode
  input  wire logic                           in_tuser,
  // output channel
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [31:0] left_command, [63:32] right_command, [95:64] speed_estimate,
  // [119:96] correction
  output      logic [wbc_pkg::OUT_DATA_W-1:0] out_tdata,
  // config port
  input  wire logic                           cfg_we,
  input  wire logic [wbc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [wbc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  // post-processing steps, one per product
  localparam logic [1:0] STEP_SPEED = 2'd0;
  localparam logic [1:0] STEP_FILT  = 2'd1;
  localparam logic [1:0] STEP_LEAN  = 2'd2;
  localparam logic [1:0] STEP_BAL   = 2'd3;

  localparam int POS_W  = wbc_pkg::POS_W;
  localparam int OPA_W  = wbc_pkg::OPA_W;
  localparam int OPB_W  = wbc_pkg::OPB_W;
  localparam int PROD_W = wbc_pkg::PROD_W;
  localparam int FSUM_W = 36;
  localparam int DIFF_W = 44;

  // config registers
  logic [15:0] speed_scale_r;
  logic [16:0] filter_alpha_r;
  logic [15:0] lean_gain_r;
  logic [15:0] balance_gain_r;

  // control
  logic [1:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;

  // datapath
  logic        [POS_W-1:0]              last_left_r, last_right_r;
  logic        [POS_W-1:0]              cur_left_r, cur_right_r;
  logic signed [wbc_pkg::PITCH_W-1:0]   pitch_r;
  logic signed [wbc_pkg::GOAL_W-1:0]    goal_r;
  logic signed [wbc_pkg::SPEED_W-1:0]   filt_r;
  logic signed [OPA_W-1:0]              opa_r;
  logic signed [OPB_W-1:0]              opb_r;
  logic signed [PROD_W-1:0]             prod_r;
  logic        [wbc_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic [POS_W-1:0] in_left, in_right;
  logic [POS_W-1:0] dl, dr;
  logic             in_acc, out_free, load_out;

  logic signed [OPA_W-1:0]   delta_sum;
  logic signed [PROD_W-1:0]  sh9, sh8, sh16;
  logic signed [POS_W-1:0]   avg_sat;
  logic signed [FSUM_W-1:0]  filt_sum;
  logic signed [POS_W-1:0]   filt_new;
  logic signed [OPA_W-1:0]   speed_err;
  logic signed [DIFF_W-1:0]  pitch_diff;
  logic signed [OPA_W-1:0]   diff_clamp;
  logic signed [wbc_pkg::CORR_W-1:0] corr_sat;
  logic [16:0]               alpha_eff;

  assign in_left  = in_tdata[31:0];
  assign in_right = in_tdata[63:32];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign load_out  = (state_r == ST_POST) && (step_r == STEP_BAL) && out_free;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // wheel deltas, right wheel mirrored
  assign dl = in_left - last_left_r;
  assign dr = last_right_r - in_right;
  assign delta_sum = {dl[POS_W-1], dl} + {dr[POS_W-1], dr};

  assign alpha_eff = (filter_alpha_r > wbc_pkg::ALPHA_ONE) ? wbc_pkg::ALPHA_ONE
                                                           : filter_alpha_r;

  // post-processing of the registered product
  always_comb begin
    sh9  = prod_r >>> wbc_pkg::SPEED_SHIFT;
    sh16 = prod_r >>> wbc_pkg::ALPHA_SHIFT;
    sh8  = prod_r >>> wbc_pkg::GAIN_SHIFT;

    // speed: saturate to 32 bits
    if ((sh9[PROD_W-1:POS_W-1] == '0) || (sh9[PROD_W-1:POS_W-1] == '1)) begin
      avg_sat = sh9[POS_W-1:0];
    end else begin
      avg_sat = sh9[PROD_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end

    // filt + a*(avg - filt)/65536
    filt_sum = FSUM_W'(filt_r) + sh16[FSUM_W-1:0];
    if ((filt_sum[FSUM_W-1:POS_W-1] == '0) || (filt_sum[FSUM_W-1:POS_W-1] == '1)) begin
      filt_new = filt_sum[POS_W-1:0];
    end else begin
      filt_new = filt_sum[FSUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                    : {1'b0, {(POS_W-1){1'b1}}};
    end
    speed_err = OPA_W'(filt_new) - OPA_W'(goal_r);

    // pitch error; beyond 33 bits the correction saturates anyway
    pitch_diff = DIFF_W'(pitch_r) - sh8[DIFF_W-1:0];
    if ((pitch_diff[DIFF_W-1:OPA_W-1] == '0) || (pitch_diff[DIFF_W-1:OPA_W-1] == '1)) begin
      diff_clamp = pitch_diff[OPA_W-1:0];
    end else begin
      diff_clamp = pitch_diff[DIFF_W-1] ? {1'b1, {(OPA_W-1){1'b0}}}
                                        : {1'b0, {(OPA_W-1){1'b1}}};
    end

    // correction: saturate to 24 bits
    if ((sh8[PROD_W-1:wbc_pkg::CORR_W-1] == '0) ||
        (sh8[PROD_W-1:wbc_pkg::CORR_W-1] == '1)) begin
      corr_sat = sh8[wbc_pkg::CORR_W-1:0];
    end else begin
      corr_sat = sh8[PROD_W-1] ? {1'b1, {(wbc_pkg::CORR_W-1){1'b0}}}
                               : {1'b0, {(wbc_pkg::CORR_W-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser == wbc_pkg::MODE_STEP)) begin
          state_nxt = ST_MUL;
          step_nxt  = STEP_SPEED;
        end
      end
      ST_MUL: begin
        state_nxt = ST_POST;
      end
      ST_POST: begin
        if (step_r != STEP_BAL) begin
          state_nxt = ST_MUL;
          step_nxt  = step_r + 2'd1;
        end else if (load_out) begin
          state_nxt      = ST_IDLE;
          step_nxt       = STEP_SPEED;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = STEP_SPEED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      step_r         <= STEP_SPEED;
      out_tvalid_r   <= 1'b0;
      speed_scale_r  <= wbc_pkg::SPEED_SCALE_RST;
      filter_alpha_r <= wbc_pkg::FILTER_ALPHA_RST;
      lean_gain_r    <= wbc_pkg::LEAN_GAIN_RST;
      balance_gain_r <= wbc_pkg::BALANCE_GAIN_RST;
      last_left_r    <= '0;
      last_right_r   <= '0;
      filt_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          wbc_pkg::REG_SPEED_SCALE:  speed_scale_r  <= cfg_wdata[15:0];
          wbc_pkg::REG_FILTER_ALPHA: filter_alpha_r <= cfg_wdata;
          wbc_pkg::REG_LEAN_GAIN:    lean_gain_r    <= cfg_wdata[15:0];
          wbc_pkg::REG_BALANCE_GAIN: balance_gain_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        last_left_r  <= in_left;
        last_right_r <= in_right;
        if (in_tuser == wbc_pkg::MODE_START) begin
          filt_r <= '0;
        end
      end
      if ((state_r == ST_POST) && (step_r == STEP_FILT)) begin
        filt_r <= filt_new;
      end
    end
  end

  // payload: operands, shared multiplier, output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_left_r  <= in_left;
      cur_right_r <= in_right;
      pitch_r     <= in_tdata[80:64];
      goal_r      <= in_tdata[96:81];
      opa_r       <= delta_sum;
      opb_r       <= OPB_W'(speed_scale_r);
    end
    if (state_r == ST_MUL) begin
      prod_r <= opa_r * opb_r;
    end
    if (state_r == ST_POST) begin
      unique case (step_r)
        STEP_SPEED: begin
          opa_r <= OPA_W'(avg_sat) - OPA_W'(filt_r);
          opb_r <= OPB_W'(alpha_eff);
        end
        STEP_FILT: begin
          opa_r <= speed_err;
          opb_r <= OPB_W'(lean_gain_r);
        end
        STEP_LEAN: begin
          opa_r <= diff_clamp;
          opb_r <= OPB_W'(balance_gain_r);
        end
        STEP_BAL: begin
          if (out_free) begin
            out_tdata_r <= {corr_sat, filt_r,
                            cur_right_r + POS_W'(corr_sat),
                            cur_left_r - POS_W'(corr_sat)};
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_step_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == wbc_pkg::MODE_STEP)) |=>
      (state_r == ST_MUL && step_r == STEP_SPEED))
    else $error("control step did not start the multiply sequence");

  a_start_clears_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == wbc_pkg::MODE_START)) |=>
      (filt_r == '0 && state_r == ST_IDLE))
    else $error("start beat did not clear the filter");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid_r || out_tready) && out_tvalid_nxt |->
      (state_r == ST_POST && step_r == STEP_BAL))
    else $error("output loaded outside the final step");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (step_r == STEP_SPEED))
    else $error("step counter not rewound at idle");

endmodule
`default_nettype wire
